// File: sv/arfp_pkg.sv
// ----------------------------------------------------------------------------
// arfp_pkg
// Shared types and constants of the ASCII range frame parser.
// ----------------------------------------------------------------------------
package arfp_pkg;

   // character codes of the frame
   localparam logic [7:0] CharY     = 8'h59;
   localparam logic [7:0] CharT     = 8'h54;
   localparam logic [7:0] CharE     = 8'h45;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   // field widths
   localparam int DistW     = 16;
   localparam int DistAccW  = 17;
   localparam int TimeW     = 32;
   localparam int DigitCntW = 4;

   // digits per field beyond which further digits are ignored
   localparam logic [DigitCntW-1:0] MaxDigits = 4'd15;

   // saturation value of the distance accumulator
   localparam logic [DistAccW-1:0] DistSat = 17'h1FFFF;

   // register map: one 32-bit register, decoded on the word address bit
   localparam int CsrAddrW = 3;
   localparam logic RegMaxDist = 1'b0;
   localparam logic [DistW-1:0] MaxDistReset = 16'd3000;

   // one parsed reading and its qualifier
   typedef struct packed {
      logic             hit;
      logic [DistW-1:0] dist_mm;
      logic [TimeW-1:0] stamp_ms;
   } arfp_result_type;

endpackage

// File: sv/arfp_csr.sv
// ----------------------------------------------------------------------------
// arfp_csr
// APB-style register file holding the distance limit.
// ----------------------------------------------------------------------------
module arfp_csr
   import arfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output logic [DistW-1:0]    max_dist_mm
);

   logic [DistW-1:0] max_dist_ff;
   logic [DistW-1:0] max_dist_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == RegMaxDist);

   always_comb begin
      max_dist_in = max_dist_ff;
      if (wr_hit) begin
         max_dist_in = pwdata[DistW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MaxDistReset;
      end else begin
         max_dist_ff <= max_dist_in;
      end
   end

   // unused address bits below the word boundary are ignored
   always_comb begin
      prdata = '0;
      if ((paddr[2] == RegMaxDist) && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00)) begin
         prdata = {{(32-DistW){1'b0}}, max_dist_ff};
      end
   end

   assign max_dist_mm = max_dist_ff;

endmodule

// File: sv/arfp_parse.sv
// ----------------------------------------------------------------------------
// arfp_parse
// Frame state machine and digit accumulators; one byte per step.
// ----------------------------------------------------------------------------
module arfp_parse
   import arfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [DistW-1:0] max_dist_mm,
   output arfp_result_type  result
);

   typedef enum logic [1:0] {
      PH_WAIT_Y1,
      PH_WAIT_Y2,
      PH_DIST,
      PH_TIME
   } phase_type;

   phase_type              phase_ff,      phase_in;
   logic [DistAccW-1:0]    dist_acc_ff,   dist_acc_in;
   logic [DigitCntW-1:0]   dist_cnt_ff,   dist_cnt_in;
   logic [TimeW-1:0]       time_acc_ff,   time_acc_in;
   logic [DigitCntW-1:0]   time_cnt_ff,   time_cnt_in;

   logic                   is_digit;
   logic [3:0]             digit;
   logic [DistAccW+3:0]    dist_ext;
   logic [DistAccW+3:0]    dist_sum;
   logic [DistAccW-1:0]    dist_step;
   logic [TimeW-1:0]       time_step;
   logic                   frame_ok;

   assign is_digit = (rx_byte >= CharZero) && (rx_byte <= CharNine);
   assign digit    = rx_byte[3:0];

   // times ten as two shifts and an add; saturate the distance
   assign dist_ext  = {4'b0, dist_acc_ff};
   assign dist_sum  = (dist_ext << 3) + (dist_ext << 1) + {{(DistAccW){1'b0}}, digit};
   assign dist_step = (dist_sum > {4'b0, DistSat}) ? DistSat : dist_sum[DistAccW-1:0];
   assign time_step = (time_acc_ff << 3) + (time_acc_ff << 1) + {{(TimeW-4){1'b0}}, digit};

   assign frame_ok = (dist_cnt_ff != '0) && (time_cnt_ff != '0) && (dist_acc_ff != '0)
                     && (dist_acc_ff <= {1'b0, max_dist_mm});

   always_comb begin
      phase_in    = phase_ff;
      dist_acc_in = dist_acc_ff;
      dist_cnt_in = dist_cnt_ff;
      time_acc_in = time_acc_ff;
      time_cnt_in = time_cnt_ff;
      result.hit      = 1'b0;
      result.dist_mm  = dist_acc_ff[DistW-1:0];
      result.stamp_ms = time_acc_ff;
      case (phase_ff)
         PH_WAIT_Y1: begin
            if (rx_byte == CharY) begin
               phase_in = PH_WAIT_Y2;
            end
         end
         PH_WAIT_Y2: begin
            if (rx_byte == CharY) begin
               dist_acc_in = '0;
               dist_cnt_in = '0;
               time_acc_in = '0;
               time_cnt_in = '0;
               phase_in    = PH_DIST;
            end else begin
               phase_in = PH_WAIT_Y1;
            end
         end
         PH_DIST: begin
            if (is_digit) begin
               if (dist_cnt_ff < MaxDigits) begin
                  dist_acc_in = dist_step;
                  dist_cnt_in = dist_cnt_ff + DigitCntW'(1);
               end
            end else if (rx_byte == CharT) begin
               phase_in = PH_TIME;
            end else begin
               phase_in = PH_WAIT_Y1;
            end
         end
         PH_TIME: begin
            if (is_digit) begin
               if (time_cnt_ff < MaxDigits) begin
                  time_acc_in = time_step;
                  time_cnt_in = time_cnt_ff + DigitCntW'(1);
               end
            end else if (rx_byte == CharE) begin
               phase_in   = PH_WAIT_Y1;
               result.hit = frame_ok;
            end else begin
               phase_in = PH_WAIT_Y1;
            end
         end
         default: begin
            phase_in = PH_WAIT_Y1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_Y1;
         dist_cnt_ff <= '0;
         time_cnt_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         dist_cnt_ff <= dist_cnt_in;
         time_cnt_ff <= time_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         dist_acc_ff <= dist_acc_in;
         time_acc_ff <= time_acc_in;
      end
   end

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_WAIT_Y2) && (rx_byte == CharY)
      |=> (phase_ff == PH_DIST) && (dist_cnt_ff == '0) && (time_cnt_ff == '0))
      else $error("second header byte did not open a clean frame");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_TIME) && (rx_byte == CharE) |=> (phase_ff == PH_WAIT_Y1))
      else $error("end byte did not close the frame");

endmodule

// File: sv/ascii_range_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_range_frame_parser
// Parses YY<distance>T<timestamp>E frames from an ASCII byte stream and
// emits one range reading per valid frame.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_rx_byte[7:0]
//   rsp       out        rsp_valid/rsp_ready   rsp_dist_mm[15:0], rsp_stamp_ms[31:0]
//   csr       in/out     psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
// One item per cycle sustained while no result stalls; a reading is offered
// on rsp once its closing item has passed the input register and then the
// parse step into the result register.
// The critical path is the times-ten add of the timestamp accumulator.
// Reset is synchronous and active high; the limit returns to 3000 mm.
// A stalled result holds the parse step; the input register then fills and
// req_ready drops, so no item is lost.
//
module ascii_range_frame_parser
   import arfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input item channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   // result item channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DistW-1:0]    rsp_dist_mm,
   output logic [TimeW-1:0]    rsp_stamp_ms,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DistW-1:0] rsp_dist_ff;
   logic [TimeW-1:0] rsp_time_ff;
   logic             advance;
   logic             take;
   logic [DistW-1:0] max_dist_mm;
   arfp_result_type  result;

   arfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .max_dist_mm (max_dist_mm)
   );

   // advance the held item once the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   arfp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .max_dist_mm (max_dist_mm),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // load a fresh reading, drop one that has been taken, else hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.hit) begin
         rsp_dist_ff <= result.dist_mm;
         rsp_time_ff <= result.stamp_ms;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dist_mm  = rsp_dist_ff;
   assign rsp_stamp_ms = rsp_time_ff;

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input item was lost or changed");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result appeared without a parse step");

endmodule

// File: verif/ascii_range_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_range_frame_parser_test
// Self-checking bench for the frame parser. A short table of hand-written
// frames, then a long stream of random frames and noise under four distance
// limits, checked against typed rows or an in-bench parser. Both sides idle
// at random; the result side is held off once long enough to back-pressure.
// ----------------------------------------------------------------------------
module ascii_range_frame_parser_test;
   import arfp_pkg::*;

   localparam int ClockPeriod    = 10;
   localparam int ResetCycles    = 8;
   localparam int CycleLimit     = 500000;
   // the parser is two stages deep; let both drain before a write
   localparam int SettleCycles   = 6;
   localparam int LongHoldCycles = 400;
   localparam int ItemsPerPhase  = 500;
   localparam int KeepLimit      = -1;
   localparam bit Typed          = 1'b1;
   localparam bit Predicted      = 1'b0;
   localparam bit Hit            = 1'b1;
   localparam bit Miss           = 1'b0;

   localparam logic [CsrAddrW-1:0] AddrMaxDist = {RegMaxDist, 2'b00};
   localparam logic [CsrAddrW-1:0] AddrSpare   = {~RegMaxDist, 2'b00};

   typedef enum logic [1:0] {SeekFirstY, SeekSecondY, TakeDist, TakeTime} parse_phase_type;

   // one hand-written stimulus row; the expected reading is typed in only
   // where it is obvious, the rest is left to the in-bench parser
   typedef struct {
      int              limit;
      string           text;
      bit              typed;
      arfp_result_type want;
   } frame_row_type;

   // ---------------------------------------------------------------------------
   // DUT and its ports; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte      = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [DistW-1:0]    rsp_dist_mm;
   logic [TimeW-1:0]    rsp_stamp_ms;
   logic                psel             = 1'b0;
   logic                penable          = 1'b0;
   logic                pwrite           = 1'b0;
   logic [CsrAddrW-1:0] paddr            = '0;
   logic [31:0]         pwdata           = '0;
   logic [31:0]         prdata;
   logic                pready;

   ascii_range_frame_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dist_mm      (rsp_dist_mm),
      .rsp_stamp_ms     (rsp_stamp_ms),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // In-bench parser state, limit register copy and bookkeeping
   // ---------------------------------------------------------------------------
   parse_phase_type      phase_q  = SeekFirstY;
   logic [DistAccW-1:0]  dist_acc = '0;
   logic [DigitCntW-1:0] dist_cnt = '0;
   logic [TimeW-1:0]     time_acc = '0;
   logic [DigitCntW-1:0] time_cnt = '0;
   logic [DistW-1:0]     limit_mm = MaxDistReset;

   arfp_result_type readings_due[$];   // readings still owed by the DUT, oldest first
   frame_row_type   frame_rows[$];

   int failures         = 0;
   int bytes_sent       = 0;
   int readings_checked = 0;
   int cycles           = 0;
   int src_gap_pct      = 0;   // chance in percent of a gap before each byte
   int sink_gap_pct     = 0;   // chance in percent of a stall burst on rsp
   bit hold_request     = 1'b0;
   bit typed_row        = 1'b0;

   // Advance the parser by one byte; hit is set when the byte closes a frame
   // that yields a reading.
   function automatic arfp_result_type parse_byte(input logic [7:0] c);
      arfp_result_type r;
      logic [31:0]     wide;
      logic            is_num;
      r      = '0;
      is_num = (c >= CharZero) && (c <= CharNine);
      case (phase_q)
         SeekFirstY: begin
            if (c == CharY) phase_q = SeekSecondY;
         end
         SeekSecondY: begin
            // a wrong second byte is not taken as a fresh first 'Y'
            if (c == CharY) begin
               dist_acc = '0;
               dist_cnt = '0;
               time_acc = '0;
               time_cnt = '0;
               phase_q  = TakeDist;
            end else begin
               phase_q = SeekFirstY;
            end
         end
         TakeDist: begin
            if (is_num) begin
               // digits past the limit are dropped; the accumulator saturates
               if (dist_cnt < MaxDigits) begin
                  wide     = 32'(dist_acc) * 32'd10 + 32'(c - CharZero);
                  dist_acc = (wide > 32'(DistSat)) ? DistSat : wide[DistAccW-1:0];
                  dist_cnt++;
               end
            end else if (c == CharT) begin
               phase_q = TakeTime;
            end else begin
               phase_q = SeekFirstY;
            end
         end
         TakeTime: begin
            if (is_num) begin
               // timestamp simply wraps at 32 bits
               if (time_cnt < MaxDigits) begin
                  time_acc = time_acc * 32'd10 + 32'(c - CharZero);
                  time_cnt++;
               end
            end else if (c == CharE) begin
               phase_q = SeekFirstY;
               if (dist_cnt != 0 && time_cnt != 0 && dist_acc != 0 &&
                   dist_acc <= DistAccW'(limit_mm)) begin
                  r.hit      = 1'b1;
                  r.dist_mm  = dist_acc[DistW-1:0];
                  r.stamp_ms = time_acc;
               end
            end else begin
               phase_q = SeekFirstY;
            end
         end
         default: begin
            phase_q = SeekFirstY;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------------
   // Offer one byte and hold it until taken. Valid is dropped only for a gap,
   // so back-to-back bytes keep it high without a glitch.
   task automatic push_byte(input logic [7:0] c);
      arfp_result_type r;
      if ($urandom_range(0, 99) < src_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      r = parse_byte(c);
      if (r.hit && !typed_row) readings_due.push_back(r);
   endtask

   // Drop valid and wait until the DUT has nothing left in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One APB transfer: setup, then access. A read is checked against the
   // register copy at the access edge.
   task automatic csr_access(input bit is_write, input logic [CsrAddrW-1:0] addr,
                             input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (is_write) begin
         if (addr == AddrMaxDist) limit_mm = data[DistW-1:0];
      end else if (prdata !== 32'(limit_mm)) begin
         $error("max_dist_mm readback: expected %0d, actual %0d", limit_mm, prdata);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change the limit while idle; junk in the upper half must be ignored.
   task automatic set_limit(input int lim);
      settle();
      csr_access(1'b1, AddrMaxDist, {16'($urandom()), 16'(lim)});
      csr_access(1'b0, AddrMaxDist, '0);
   endtask

   // Send one numeric field: mostly a plain number, sometimes with leading
   // zeros, now and then empty or longer than the digit limit.
   task automatic send_field(input longint unsigned v);
      string s;
      int    pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return;
      if (pick == 1) begin
         repeat ($urandom_range(16, 18)) push_byte(CharZero + 8'($urandom_range(0, 9)));
         return;
      end
      if (pick == 2) repeat ($urandom_range(1, 3)) push_byte(CharZero);
      s = $sformatf("%0d", v);
      for (int k = 0; k < s.len(); k++) push_byte(s[k]);
   endtask

   // Mostly well-formed frames with random content; the rest is line noise
   // or a frame broken at the header, the separator or the terminator.
   task automatic send_random_frame();
      int              kind;
      longint unsigned dist_val;
      longint unsigned stamp;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         return;
      end
      push_byte(CharY);
      push_byte((kind < 13) ? 8'($urandom_range(0, 255)) : CharY);
      case ($urandom_range(0, 3))
         0:       dist_val = $urandom_range(0, 3);
         1:       dist_val = longint'(limit_mm) + $urandom_range(0, 4);
         2:       dist_val = $urandom_range(0, 140000);
         default: dist_val = $urandom_range(0, limit_mm);
      endcase
      // centre the second pick on the limit itself
      if (dist_val >= 2 && dist_val > longint'(limit_mm)) dist_val = dist_val - 2;
      send_field(dist_val);
      push_byte((kind < 16) ? 8'($urandom_range(0, 255)) : CharT);
      stamp = $urandom_range(0, 1) ? longint'($urandom()) : $urandom_range(0, 999);
      if ($urandom_range(0, 9) == 0) stamp = stamp * 4000000000;   // force a wrap
      send_field(stamp);
      push_byte((kind < 19) ? 8'($urandom_range(0, 255)) : CharE);
   endtask

   task automatic add_row(input int lim, input string text, input bit typed,
                          input bit hit, input int unsigned dist_val,
                          input int unsigned stamp);
      frame_row_type row;
      row.limit          = lim;
      row.text           = text;
      row.typed          = typed;
      row.want.hit       = hit;
      row.want.dist_mm   = dist_val[DistW-1:0];
      row.want.stamp_ms  = stamp;
      frame_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: score each reading, then decide ready for the next cycle.
   // Stalls come in random bursts, plus one long hold-off on request.
   // ---------------------------------------------------------------------------
   initial begin : reading_sink
      arfp_result_type want;
      int              stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $error("reading with none owed: dist_mm %0d, stamp_ms %0d",
                      rsp_dist_mm, rsp_stamp_ms);
               failures++;
            end else begin
               want = readings_due.pop_front();
               readings_checked++;
               if (rsp_dist_mm !== want.dist_mm) begin
                  $error("dist_mm: expected %0d, actual %0d", want.dist_mm, rsp_dist_mm);
                  failures++;
               end
               if (rsp_stamp_ms !== want.stamp_ms) begin
                  $error("stamp_ms: expected %0d, actual %0d",
                         want.stamp_ms, rsp_stamp_ms);
                  failures++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = LongHoldCycles;
         end else if (stall == 0 && $urandom_range(0, 99) < sink_gap_pct) begin
            stall = $urandom_range(1, 13);
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // hard stop should the DUT hang
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $error("timeout after %0d cycles, %0d readings still owed",
                cycles, readings_due.size());
         $display("ascii_range_frame_parser_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int lim;
      int target;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // limit must come up at its reset value; a write to the unused
      // address must leave it alone
      csr_access(1'b0, AddrMaxDist, '0);
      csr_access(1'b1, AddrSpare, 32'h0000_1234);
      csr_access(1'b0, AddrMaxDist, '0);

      // directed frames: limit boundaries, empty fields, header slips,
      // aborts, saturation, excess digits and timestamp wrap
      add_row(KeepLimit, "YY3000T0E",                Typed, Hit, 3000, 0);
      add_row(KeepLimit, "YY3001T5E",                Typed, Miss, 0, 0);
      add_row(KeepLimit, "YY0T7E",                   Typed, Miss, 0, 0);
      add_row(KeepLimit, "YYT7E",                    Typed, Miss, 0, 0);
      add_row(KeepLimit, "YY12TE",                   Typed, Miss, 0, 0);
      add_row(KeepLimit, "YAYY9T9E",                 Typed, Hit, 9, 9);
      add_row(KeepLimit, "Y5T1EYY12X3T4E",           Typed, Miss, 0, 0);
      add_row(KeepLimit, "YYY1T2EYY007T42E",         Predicted, Miss, 0, 0);
      add_row(65535,     "YY65535T4294967295E",      Typed, Hit, 65535, 32'hFFFF_FFFF);
      add_row(KeepLimit, "YY65536T1E",               Typed, Miss, 0, 0);
      add_row(KeepLimit, "YY99999999999999999T1E",   Typed, Miss, 0, 0);
      add_row(KeepLimit, "YY00000000000001234T8E",   Predicted, Miss, 0, 0);
      add_row(KeepLimit, "YY1T99999999999999999E",   Predicted, Miss, 0, 0);
      add_row(1,         "YY1T0E",                   Typed, Hit, 1, 0);
      add_row(KeepLimit, "YY2T0E",                   Typed, Miss, 0, 0);
      add_row(0,         "YY1T0E",                   Typed, Miss, 0, 0);
      add_row(3000,      "YY2999T1E",                Predicted, Miss, 0, 0);

      src_gap_pct  = 20;
      sink_gap_pct = 20;
      foreach (frame_rows[i]) begin
         if (frame_rows[i].limit != KeepLimit) set_limit(frame_rows[i].limit);
         typed_row = frame_rows[i].typed;
         for (int k = 0; k < frame_rows[i].text.len(); k++) push_byte(frame_rows[i].text[k]);
         // every typed hit ends on its last byte, so queue it now
         if (typed_row && frame_rows[i].want.hit) readings_due.push_back(frame_rows[i].want);
         typed_row = 1'b0;
      end

      // random stream under four limits; the second phase carries the long
      // hold-off, the last runs flat out on both sides
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       lim = 65535;
            1:       lim = $urandom_range(1, 65535);
            2:       lim = 1;
            default: lim = MaxDistReset;
         endcase
         set_limit(lim);
         src_gap_pct  = (p == 3) ? 0 : $urandom_range(5, 40);
         sink_gap_pct = (p == 3) ? 0 : $urandom_range(5, 40);
         if (p == 1) hold_request = 1'b1;
         target = bytes_sent + ItemsPerPhase;
         while (bytes_sent < target) send_random_frame();
      end

      settle();
      $display("Sent %0d bytes: directed frames, then random frames and noise", bytes_sent);
      $display("Scored %0d readings under limits 0, 1, 3000, 65535 and one random value",
               readings_checked);
      if (failures == 0) begin
         $display("ascii_range_frame_parser_test passed");
      end else begin
         $display("ascii_range_frame_parser_test failed");
      end
      $finish;
   end

endmodule
